// ----- hdl/assert_macros.svh -----
// assertion helpers used by the rtl sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GGS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define GGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- hdl/ggs_pkg.sv -----
`default_nettype none
package ggs_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN = 24;
	localparam int CORDIC_N = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam int CORDIC_CNT_W = $clog2(CORDIC_N);
	localparam int CORDIC_IN_W = 34;
	localparam int CORDIC_W = 37;
	localparam int ANGLE_W = 16;

	localparam int SQRT_STEPS = 32;
	localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

	localparam logic signed [ANGLE_W-1:0] PI_Q = 16'sd12868;
	localparam logic signed [ANGLE_W-1:0] TWO_PI_Q = 16'sd25736;
	localparam logic signed [ANGLE_W-1:0] HALF_PI_Q = 16'sd6434;

	localparam int POS_W = 32;
	localparam int QUAT_W = 16;
	localparam int GAIN_W = 16;
	localparam int LIN_W = 15;
	localparam int ANG_W = 16;
	localparam int RADIUS_W = 31;
	localparam int FUNC_W = 2;
	localparam int IN_TDATA_W = 128;
	localparam int OUT_TDATA_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int QIDX_W = 3;
	localparam logic [QIDX_W-1:0] QPROD_LAST = 3'd7;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_POSE = 2'd0,
		FUNC_TICK = 2'd1,
		FUNC_ARM  = 2'd2
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GOAL_X       = 3'd0,
		CFG_GOAL_Y       = 3'd1,
		CFG_GAIN_LINEAR  = 3'd2,
		CFG_GAIN_HEADING = 3'd3,
		CFG_MAX_LINEAR   = 3'd4,
		CFG_MAX_ANGULAR  = 3'd5,
		CFG_REACH_RADIUS = 3'd6
	} cfg_idx_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_POSE,
		OP_DIFF,
		OP_SQX,
		OP_SQY,
		OP_SUM,
		OP_SQRT_GO,
		OP_DIST,
		OP_REACH,
		OP_BEAR_GO,
		OP_BEAR,
		OP_QMUL,
		OP_YAWARG,
		OP_YAW_GO,
		OP_ERR,
		OP_MUL,
		OP_CLAMP,
		OP_PUT
	} dp_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIFF,
		S_SQX,
		S_SQY,
		S_SUM,
		S_SQRT_GO,
		S_SQRT_WAIT,
		S_CHECK,
		S_BEAR_WAIT,
		S_QMUL,
		S_YAWARG,
		S_YAW_GO,
		S_YAW_WAIT,
		S_MUL,
		S_CLAMP,
		S_PUT
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t             op;
		logic [QIDX_W-1:0]  qidx;
	} ggs_cmd_t;

	typedef struct packed {
		logic sqrt_done;
		logic cordic_done;
		logic reached;
	} ggs_stat_t;

	// arctan(2^-i) in units of 2^-28 rad
	function automatic logic [27:0] atan_entry(input logic [4:0] i);
		logic [27:0] v;
		case (i)
			5'd0:  v = 28'd210828714;
			5'd1:  v = 28'd124459457;
			5'd2:  v = 28'd65760959;
			5'd3:  v = 28'd33381290;
			5'd4:  v = 28'd16755422;
			5'd5:  v = 28'd8385879;
			5'd6:  v = 28'd4193963;
			5'd7:  v = 28'd2097109;
			5'd8:  v = 28'd1048571;
			5'd9:  v = 28'd524287;
			5'd10: v = 28'd262144;
			5'd11: v = 28'd131072;
			5'd12: v = 28'd65536;
			5'd13: v = 28'd32768;
			5'd14: v = 28'd16384;
			5'd15: v = 28'd8192;
			5'd16: v = 28'd4096;
			5'd17: v = 28'd2048;
			5'd18: v = 28'd1024;
			5'd19: v = 28'd512;
			5'd20: v = 28'd256;
			5'd21: v = 28'd128;
			5'd22: v = 28'd64;
			5'd23: v = 28'd32;
			default: v = 28'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/ggs_isqrt.sv -----
`default_nettype none
// restoring square root, one result bit per cycle
module ggs_isqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output logic             done,
	output logic [31:0]      root
);

	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [ggs_pkg::SQRT_CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [35:0] rem_sh;
	logic [35:0] trial;
	logic [35:0] diff;
	logic ge;

	always_comb begin
		rem_sh = {rem_q, rad_q[63:62]};
		trial  = {2'b00, root_q, 2'b01};
		diff   = rem_sh - trial;
		ge     = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == ggs_pkg::SQRT_CNT_W'(ggs_pkg::SQRT_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (ge) begin
				rem_q  <= diff[33:0];
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[33:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

// ----- hdl/ggs_cordic.sv -----
`default_nettype none
// iterative vectoring cordic atan2, one rotation per cycle
module ggs_cordic (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	input  wire logic signed [ggs_pkg::CORDIC_IN_W-1:0] x_in,
	input  wire logic signed [ggs_pkg::CORDIC_IN_W-1:0] y_in,
	output logic                                        done,
	output logic signed [ggs_pkg::ANGLE_W-1:0]          angle
);

	localparam int CW = ggs_pkg::CORDIC_W;
	localparam int IW = ggs_pkg::CORDIC_IN_W;

	logic signed [CW-1:0] ax_q, ay_q;
	logic signed [31:0] z_q;
	logic [ggs_pkg::CORDIC_CNT_W-1:0] cnt_q;
	logic busy_q, done_q;
	logic xneg_q, yneg_q, zero_q;

	logic signed [CW-1:0] x_ext, y_ext, ax_sh, ay_sh, nx, ny;
	logic signed [31:0] ent, nz, zc, ar;
	logic signed [ggs_pkg::ANGLE_W-1:0] a, r;

	always_comb begin
		x_ext = {{(CW-IW){x_in[IW-1]}}, x_in};
		y_ext = {{(CW-IW){y_in[IW-1]}}, y_in};
		ax_sh = ax_q >>> cnt_q;
		ay_sh = ay_q >>> cnt_q;
		ent   = $signed({4'b0000, ggs_pkg::atan_entry(5'(cnt_q))});
		if (!ay_q[CW-1]) begin
			nx = ax_q + ay_sh;
			ny = ay_q - ax_sh;
			nz = z_q + ent;
		end else begin
			nx = ax_q - ay_sh;
			ny = ay_q + ax_sh;
			nz = z_q - ent;
		end
	end

	// round to q4.12, clamp, then place in quadrant
	always_comb begin
		zc = z_q[31] ? 32'sd0 : z_q;
		ar = (zc + 32'sd32768) >>> 16;
		if (ar > 32'(ggs_pkg::HALF_PI_Q))
			a = ggs_pkg::HALF_PI_Q;
		else
			a = ar[ggs_pkg::ANGLE_W-1:0];
		if (zero_q) begin
			r = '0;
		end else if (!yneg_q) begin
			r = xneg_q ? (ggs_pkg::PI_Q - a) : a;
		end else if (!xneg_q) begin
			r = -a;
		end else begin
			r = a - ggs_pkg::PI_Q;
			if (r <= -ggs_pkg::PI_Q)
				r = ggs_pkg::PI_Q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == ggs_pkg::CORDIC_CNT_W'(ggs_pkg::CORDIC_N - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ax_q   <= x_ext[CW-1] ? -x_ext : x_ext;
			ay_q   <= y_ext[CW-1] ? -y_ext : y_ext;
			z_q    <= '0;
			xneg_q <= x_in[IW-1];
			yneg_q <= y_in[IW-1];
			zero_q <= (x_in == '0) && (y_in == '0);
		end else if (busy_q) begin
			ax_q <= nx;
			ay_q <= ny;
			z_q  <= nz;
		end
	end

	assign done  = done_q;
	assign angle = r;

endmodule
`default_nettype wire

// ----- hdl/ggs_dp.sv -----
`default_nettype none
// datapath: registers, operand muxes, multipliers (the squaring and quaternion ones shared), sqrt and cordic units
module ggs_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire ggs_pkg::ggs_cmd_t                   cmd,
	output ggs_pkg::ggs_stat_t                       stat,
	input  wire logic [ggs_pkg::IN_TDATA_W-1:0]      in_data,
	input  wire logic                                cfg_we,
	input  wire logic [ggs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [ggs_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic [ggs_pkg::LIN_W-1:0]                linear_cmd,
	output logic signed [ggs_pkg::ANG_W-1:0]         angular_cmd,
	output logic                                     goal_reached
);

	localparam int IW = ggs_pkg::CORDIC_IN_W;

	// configuration and pose
	logic signed [31:0] goal_x_q, goal_y_q, cur_x_q, cur_y_q;
	logic [15:0] gain_lin_q, gain_head_q;
	logic [14:0] max_lin_q, max_ang_q;
	logic [30:0] radius_q;
	logic signed [15:0] qx_q, qy_q, qz_q, qw_q;

	// work registers
	logic signed [32:0] dx_q, dy_q;
	logic [31:0] ux_q, uy_q;
	logic [63:0] sx_q, sy_q;
	logic [64:0] sum_q;
	logic [31:0] dist_q;
	logic signed [15:0] bear_q;
	logic signed [31:0] qp_q [8];
	logic signed [IW-1:0] yarg_x_q, yarg_y_q;
	logic gimbal_q;
	logic signed [15:0] err_q;
	logic [47:0] linp_q;
	logic signed [32:0] angp_q;
	logic [14:0] lin_q;
	logic signed [15:0] ang_q;
	logic reached_q;
	logic [14:0] out_lin_q;
	logic signed [15:0] out_ang_q;
	logic out_reached_q;

	// combinational
	logic signed [32:0] dx_c, dy_c;
	logic [31:0] sq_op;
	logic [63:0] sq_c;
	logic signed [15:0] qa, qb;
	logic signed [31:0] qprod;
	logic signed [33:0] n_c, g_c, gabs_c, yy_c, yx_c;
	logic sqrt_done, cordic_done, cordic_start;
	logic [31:0] root;
	logic signed [15:0] cangle, yaw_c;
	logic signed [IW-1:0] cx, cy;
	logic signed [16:0] e17;
	logic [31:0] lin_full;
	logic signed [20:0] ang_full, maxs;

	always_comb begin
		dx_c  = {goal_x_q[31], goal_x_q} - {cur_x_q[31], cur_x_q};
		dy_c  = {goal_y_q[31], goal_y_q} - {cur_y_q[31], cur_y_q};
		sq_op = (cmd.op == ggs_pkg::OP_SQY) ? uy_q : ux_q;
		sq_c  = sq_op * sq_op;
	end

	// products: xx yy zz ww xz wy xy wz
	always_comb begin
		unique case (cmd.qidx)
			3'd0: begin qa = qx_q; qb = qx_q; end
			3'd1: begin qa = qy_q; qb = qy_q; end
			3'd2: begin qa = qz_q; qb = qz_q; end
			3'd3: begin qa = qw_q; qb = qw_q; end
			3'd4: begin qa = qx_q; qb = qz_q; end
			3'd5: begin qa = qw_q; qb = qy_q; end
			3'd6: begin qa = qx_q; qb = qy_q; end
			default: begin qa = qw_q; qb = qz_q; end
		endcase
		qprod = qa * qb;
	end

	always_comb begin
		n_c = {{2{qp_q[0][31]}}, qp_q[0]} + {{2{qp_q[1][31]}}, qp_q[1]}
			+ {{2{qp_q[2][31]}}, qp_q[2]} + {{2{qp_q[3][31]}}, qp_q[3]};
		g_c = ({{2{qp_q[4][31]}}, qp_q[4]} - {{2{qp_q[5][31]}}, qp_q[5]}) <<< 1;
		yy_c = ({{2{qp_q[6][31]}}, qp_q[6]} + {{2{qp_q[7][31]}}, qp_q[7]}) <<< 1;
		yx_c = n_c - (({{2{qp_q[1][31]}}, qp_q[1]} + {{2{qp_q[2][31]}}, qp_q[2]}) <<< 1);
		gabs_c = g_c[33] ? -g_c : g_c;
	end

	always_comb begin
		cordic_start = (cmd.op == ggs_pkg::OP_BEAR_GO) || (cmd.op == ggs_pkg::OP_YAW_GO);
		if (cmd.op == ggs_pkg::OP_YAW_GO) begin
			cx = yarg_x_q;
			cy = yarg_y_q;
		end else begin
			cx = {dx_q[32], dx_q};
			cy = {dy_q[32], dy_q};
		end
	end

	always_comb begin
		yaw_c = gimbal_q ? 16'sd0 : cangle;
		e17 = {bear_q[15], bear_q} - {yaw_c[15], yaw_c};
		if (e17 > 17'(ggs_pkg::PI_Q))
			e17 = e17 - 17'(ggs_pkg::TWO_PI_Q);
		lin_full = linp_q[47:16];
		ang_full = angp_q[32:12];
		maxs = {6'b000000, max_ang_q};
	end

	ggs_isqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == ggs_pkg::OP_SQRT_GO),
		.radicand (sum_q[63:0]),
		.done     (sqrt_done),
		.root     (root)
	);

	ggs_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.x_in   (cx),
		.y_in   (cy),
		.done   (cordic_done),
		.angle  (cangle)
	);

	// registers and pose hold state across items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q    <= '0;
			goal_y_q    <= '0;
			gain_lin_q  <= 16'd256;
			gain_head_q <= 16'd256;
			max_lin_q   <= 15'd256;
			max_ang_q   <= 15'd256;
			radius_q    <= 31'd6554;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			qx_q        <= '0;
			qy_q        <= '0;
			qz_q        <= '0;
			qw_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (ggs_pkg::cfg_idx_t'(cfg_index))
					ggs_pkg::CFG_GOAL_X:       goal_x_q    <= cfg_data;
					ggs_pkg::CFG_GOAL_Y:       goal_y_q    <= cfg_data;
					ggs_pkg::CFG_GAIN_LINEAR:  gain_lin_q  <= cfg_data[15:0];
					ggs_pkg::CFG_GAIN_HEADING: gain_head_q <= cfg_data[15:0];
					ggs_pkg::CFG_MAX_LINEAR:   max_lin_q   <= cfg_data[14:0];
					ggs_pkg::CFG_MAX_ANGULAR:  max_ang_q   <= cfg_data[14:0];
					ggs_pkg::CFG_REACH_RADIUS: radius_q    <= cfg_data[30:0];
					default: ;
				endcase
			end
			if (cmd.op == ggs_pkg::OP_POSE) begin
				cur_x_q <= in_data[31:0];
				cur_y_q <= in_data[63:32];
				qx_q    <= in_data[79:64];
				qy_q    <= in_data[95:80];
				qz_q    <= in_data[111:96];
				qw_q    <= in_data[127:112];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			ggs_pkg::OP_DIFF: begin
				dx_q <= dx_c;
				dy_q <= dy_c;
				ux_q <= dx_c[32] ? 32'(-dx_c) : dx_c[31:0];
				uy_q <= dy_c[32] ? 32'(-dy_c) : dy_c[31:0];
			end
			ggs_pkg::OP_SQX: sx_q <= sq_c;
			ggs_pkg::OP_SQY: sy_q <= sq_c;
			ggs_pkg::OP_SUM: sum_q <= {1'b0, sx_q} + {1'b0, sy_q};
			ggs_pkg::OP_DIST: dist_q <= sum_q[64] ? 32'hFFFF_FFFF : root;
			ggs_pkg::OP_REACH: begin
				lin_q     <= '0;
				ang_q     <= '0;
				reached_q <= 1'b1;
			end
			ggs_pkg::OP_BEAR: bear_q <= cangle[15] ? (cangle + ggs_pkg::TWO_PI_Q) : cangle;
			ggs_pkg::OP_QMUL: qp_q[cmd.qidx] <= qprod;
			ggs_pkg::OP_YAWARG: begin
				yarg_x_q <= yx_c;
				yarg_y_q <= yy_c;
				gimbal_q <= ($unsigned(gabs_c) >= $unsigned(n_c));
			end
			ggs_pkg::OP_ERR: err_q <= e17[15:0];
			ggs_pkg::OP_MUL: begin
				linp_q <= gain_lin_q * dist_q;
				angp_q <= $signed({1'b0, gain_head_q}) * err_q;
			end
			ggs_pkg::OP_CLAMP: begin
				lin_q <= (lin_full > {17'd0, max_lin_q}) ? max_lin_q : lin_full[14:0];
				if (ang_full > maxs)
					ang_q <= maxs[15:0];
				else if (ang_full < -maxs)
					ang_q <= 16'(-maxs);
				else
					ang_q <= ang_full[15:0];
				reached_q <= 1'b0;
			end
			ggs_pkg::OP_PUT: begin
				out_lin_q     <= lin_q;
				out_ang_q     <= ang_q;
				out_reached_q <= reached_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.sqrt_done   = sqrt_done;
		stat.cordic_done = cordic_done;
		stat.reached     = (dist_q <= {1'b0, radius_q});
	end

	assign linear_cmd   = out_lin_q;
	assign angular_cmd  = out_ang_q;
	assign goal_reached = out_reached_q;

endmodule
`default_nettype wire

// ----- hdl/ggs_ctrl.sv -----
`default_nettype none
`include "assert_macros.svh"
// sequencer: takes pose and arm items and steps the datapath through one control tick
module ggs_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [ggs_pkg::FUNC_W-1:0]    func,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output ggs_pkg::ggs_cmd_t                  cmd,
	input  wire ggs_pkg::ggs_stat_t            stat
);

	ggs_pkg::ctrl_state_t state_q, state_d;
	logic armed_q;
	logic m_valid_q;
	logic [ggs_pkg::QIDX_W-1:0] qidx_q;
	ggs_pkg::func_t f;
	logic out_free;

	assign f = ggs_pkg::func_t'(func);
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ggs_pkg::S_IDLE:
				if (s_tvalid && f == ggs_pkg::FUNC_TICK && armed_q) state_d = ggs_pkg::S_DIFF;
			ggs_pkg::S_DIFF:      state_d = ggs_pkg::S_SQX;
			ggs_pkg::S_SQX:       state_d = ggs_pkg::S_SQY;
			ggs_pkg::S_SQY:       state_d = ggs_pkg::S_SUM;
			ggs_pkg::S_SUM:       state_d = ggs_pkg::S_SQRT_GO;
			ggs_pkg::S_SQRT_GO:   state_d = ggs_pkg::S_SQRT_WAIT;
			ggs_pkg::S_SQRT_WAIT: if (stat.sqrt_done) state_d = ggs_pkg::S_CHECK;
			ggs_pkg::S_CHECK:
				state_d = stat.reached ? ggs_pkg::S_PUT : ggs_pkg::S_BEAR_WAIT;
			ggs_pkg::S_BEAR_WAIT: if (stat.cordic_done) state_d = ggs_pkg::S_QMUL;
			ggs_pkg::S_QMUL:
				if (qidx_q == ggs_pkg::QPROD_LAST) state_d = ggs_pkg::S_YAWARG;
			ggs_pkg::S_YAWARG:    state_d = ggs_pkg::S_YAW_GO;
			ggs_pkg::S_YAW_GO:    state_d = ggs_pkg::S_YAW_WAIT;
			ggs_pkg::S_YAW_WAIT:  if (stat.cordic_done) state_d = ggs_pkg::S_MUL;
			ggs_pkg::S_MUL:       state_d = ggs_pkg::S_CLAMP;
			ggs_pkg::S_CLAMP:     state_d = ggs_pkg::S_PUT;
			ggs_pkg::S_PUT:       if (out_free) state_d = ggs_pkg::S_IDLE;
			default:              state_d = ggs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = ggs_pkg::OP_NONE;
		cmd.qidx = qidx_q;
		s_tready = (state_q == ggs_pkg::S_IDLE);
		unique case (state_q)
			ggs_pkg::S_IDLE:
				if (s_tvalid && f == ggs_pkg::FUNC_POSE) cmd.op = ggs_pkg::OP_POSE;
			ggs_pkg::S_DIFF:      cmd.op = ggs_pkg::OP_DIFF;
			ggs_pkg::S_SQX:       cmd.op = ggs_pkg::OP_SQX;
			ggs_pkg::S_SQY:       cmd.op = ggs_pkg::OP_SQY;
			ggs_pkg::S_SUM:       cmd.op = ggs_pkg::OP_SUM;
			ggs_pkg::S_SQRT_GO:   cmd.op = ggs_pkg::OP_SQRT_GO;
			ggs_pkg::S_SQRT_WAIT: if (stat.sqrt_done) cmd.op = ggs_pkg::OP_DIST;
			ggs_pkg::S_CHECK:
				cmd.op = stat.reached ? ggs_pkg::OP_REACH : ggs_pkg::OP_BEAR_GO;
			ggs_pkg::S_BEAR_WAIT: if (stat.cordic_done) cmd.op = ggs_pkg::OP_BEAR;
			ggs_pkg::S_QMUL:      cmd.op = ggs_pkg::OP_QMUL;
			ggs_pkg::S_YAWARG:    cmd.op = ggs_pkg::OP_YAWARG;
			ggs_pkg::S_YAW_GO:    cmd.op = ggs_pkg::OP_YAW_GO;
			ggs_pkg::S_YAW_WAIT:  if (stat.cordic_done) cmd.op = ggs_pkg::OP_ERR;
			ggs_pkg::S_MUL:       cmd.op = ggs_pkg::OP_MUL;
			ggs_pkg::S_CLAMP:     cmd.op = ggs_pkg::OP_CLAMP;
			ggs_pkg::S_PUT:       if (out_free) cmd.op = ggs_pkg::OP_PUT;
			default:              cmd.op = ggs_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ggs_pkg::S_IDLE;
			armed_q   <= 1'b0;
			m_valid_q <= 1'b0;
			qidx_q    <= '0;
		end else begin
			state_q <= state_d;
			qidx_q  <= (state_q == ggs_pkg::S_QMUL) ? qidx_q + 1'b1 : '0;
			if (state_q == ggs_pkg::S_IDLE && s_tvalid && f == ggs_pkg::FUNC_ARM)
				armed_q <= 1'b1;
			else if (state_q == ggs_pkg::S_CHECK && stat.reached)
				armed_q <= 1'b0;
			if (cmd.op == ggs_pkg::OP_PUT)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;

	`GGS_ASSERT_IMPL(a_run_armed, clk, arst_n, state_q == ggs_pkg::S_DIFF, armed_q)
	`GGS_ASSERT_NEXT(a_reach_disarm, clk, arst_n, state_q == ggs_pkg::S_CHECK && stat.reached, !armed_q && state_q == ggs_pkg::S_PUT)
	`GGS_ASSERT_NEXT(a_put_valid, clk, arst_n, cmd.op == ggs_pkg::OP_PUT, m_valid_q)

endmodule
`default_nettype wire

// ----- hdl/go_to_goal_steering_top.sv -----
`default_nettype none
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata pose+quaternion, tuser func
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata commands, tuser goal_reached
// cfg       in   cfg_we (no wait)               cfg_index, cfg_data
//
// pose and arm items are taken in idle; unarmed ticks are taken there and dropped
// an armed tick holds the input from its transfer through the 32-step square root
// and, when the goal is not reached, two 16-step cordic passes, the result becoming
// valid as the input is released
// arst_n clears the sequencer, armed flag, output valid, config registers and pose
// a finished result waits in the output register while the next item is taken;
// a tick waits in its last step only while an earlier result is still untaken
module go_to_goal_steering_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// pos_x[31:0] pos_y[63:32] quat_x[79:64] quat_y[95:80] quat_z[111:96] quat_w[127:112]
	input  wire logic [ggs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// func[1:0]
	input  wire logic [ggs_pkg::FUNC_W-1:0]         s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// linear_cmd[14:0] angular_cmd[30:15], zero pad
	output logic [ggs_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
	// goal_reached[0]
	output logic [0:0]                              m_axis_tuser,
	input  wire logic                               cfg_we,
	input  wire logic [ggs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ggs_pkg::CFG_DATA_W-1:0]     cfg_data
);

	ggs_pkg::ggs_cmd_t  cmd;
	ggs_pkg::ggs_stat_t stat;
	logic [ggs_pkg::LIN_W-1:0] linear_cmd;
	logic signed [ggs_pkg::ANG_W-1:0] angular_cmd;
	logic goal_reached;

	// sequencer
	ggs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.func     (s_axis_tuser),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// arithmetic, registers and output payload
	ggs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_data      (s_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.linear_cmd   (linear_cmd),
		.angular_cmd  (angular_cmd),
		.goal_reached (goal_reached)
	);

	// pack the result transfer
	assign m_axis_tdata = {1'b0, angular_cmd, linear_cmd};
	assign m_axis_tuser = goal_reached;

endmodule
`default_nettype wire
